/* rtl/pnmhp_pkg.sv */
// Package for the PNM header parser: character constants, codes and byte classifiers.
// Depends on nothing; compiled first.
`default_nettype none

package pnmhp_pkg;

    // Default field widths.
    localparam int DIM_BITS_DEF     = 16;
    localparam int HDR_LEN_BITS_DEF = 12;

    // Characters that the header grammar cares about.
    localparam logic [7:0] CH_P     = "P";
    localparam logic [7:0] CH_5     = "5";
    localparam logic [7:0] CH_6     = "6";
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_1     = "1";
    localparam logic [7:0] CH_7     = "7";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LO_A  = "a";
    localparam logic [7:0] CH_LO_F  = "f";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_F  = "F";
    localparam logic [7:0] CH_LO_X  = "x";
    localparam logic [7:0] CH_UP_X  = "X";

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_MAGIC0  = 6'b000001,
        PH_MAGIC1  = 6'b000010,
        PH_SKIP    = 6'b000100,
        PH_SKIP_WS = 6'b001000,
        PH_NUMBER  = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    // Which header number is being read.
    typedef enum logic [1:0] {
        FLD_WIDTH  = 2'd0,
        FLD_HEIGHT = 2'd1,
        FLD_MAXVAL = 2'd2
    } field_t;

    // Number base of the value being read.
    typedef enum logic [1:0] {
        RX_DEC     = 2'd0,
        RX_OCT     = 2'd1,
        RX_HEX     = 2'd2,
        RX_HEXPEND = 2'd3
    } radix_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_ZERO_W    = 3'd2,
        ST_ZERO_H    = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_GREY    = 2'd0,
        KIND_COLOUR  = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    // Outcome of handling one byte in one pass.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_RESULT = 2'd1,
        ACT_AGAIN  = 2'd2
    } act_t;

    // Whitespace: space, tab, newline, vertical tab, form feed, carriage return.
    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    // Hex digit decode: bit 4 marks a valid digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if ((b >= CH_0) && (b <= CH_9))
        begin
            r = {1'b1, b[3:0]};
        end
        else if (((b >= CH_LO_A) && (b <= CH_LO_F)) || ((b >= CH_UP_A) && (b <= CH_UP_F)))
        begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/pnmhp_if.sv */
// Handshake interfaces for the PNM header parser: the byte channel and the result channel.
// Depends on pnmhp_pkg for default widths.
`default_nettype none

// Header bytes, one word per byte.
interface pnmhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// Parsed header, one word per header.
interface pnmhp_out_if import pnmhp_pkg::*;
#(
    parameter int DIM_BITS        = DIM_BITS_DEF,
    parameter int HEADER_LEN_BITS = HDR_LEN_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [1:0]                 image_kind;
    logic [DIM_BITS-1:0]        width;
    logic [DIM_BITS-1:0]        height;
    logic [DIM_BITS-1:0]        max_value;
    logic [HEADER_LEN_BITS-1:0] header_length;

    modport source (output valid, status, image_kind, width, height, max_value,
                    header_length, input ready);
    modport sink   (input valid, status, image_kind, width, height, max_value,
                    header_length, output ready);
endinterface

`default_nettype wire

/* rtl/pnmhp_out_buf.sv */
// Two-entry result buffer (output register plus skid register) for the PNM header parser.
// Generic over the payload width; no package dependency.
`default_nettype none

module pnmhp_out_buf
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  logic [DATA_W-1:0] push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg;
    logic [DATA_W-1:0] skid_data_next;
    logic              out_free;

    // The producer pushes only while the skid register is empty.
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // The output register refills from the skid first, else from a new word.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push_valid;
                out_data_next  = push_data;
            end
        end
        else if (push_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

/* rtl/pnm_header_parser.sv */
// Top level of the binary PNM (P5/P6) header parser.
// Depends on pnmhp_pkg, pnmhp_if (pnmhp_in_if, pnmhp_out_if) and pnmhp_out_buf.
//
//   Channel   Modport   Word
//   -------   -------   -------------------------------------------------------
//   bytes     sink      data_byte, first_byte, last_byte (one header byte)
//   result    source    status, image_kind, width, height, max_value,
//                       header_length (one parsed header)
//
// One byte is taken every cycle while the result buffer has room; a byte passes
// an input register, then the parser logic updates its state and may write a
// result word into the result buffer.
// Results sit in a two-entry buffer; bytes keep flowing while one result waits,
// and bytes stall only when both entries are full.
// Reset (rst_n low) clears the parser state to "waiting for the P"; first_byte
// also restarts the parser with that byte as byte one.
`default_nettype none

module pnm_header_parser import pnmhp_pkg::*;
#(
    parameter int DIM_BITS        = DIM_BITS_DEF,
    parameter int HEADER_LEN_BITS = HDR_LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pnmhp_in_if.sink    bytes,
    pnmhp_out_if.source result
);

    // Extra headroom for one shift-add step of the accumulator.
    localparam int ACC_W     = DIM_BITS + 1;
    localparam int ACC_EXT_W = DIM_BITS + 5;

    typedef struct packed {
        phase_t                     phase;
        field_t                     field;
        logic                       nl;
        logic                       cmt;
        radix_t                     radix;
        logic [ACC_W-1:0]           acc;
        kind_t                      kind;
        logic [DIM_BITS-1:0]        wid;
        logic [DIM_BITS-1:0]        hgt;
        logic [HEADER_LEN_BITS-1:0] cnt;
        logic                       ovf;
    } pstate_t;

    typedef struct packed {
        status_t                    status;
        kind_t                      image_kind;
        logic [DIM_BITS-1:0]        width;
        logic [DIM_BITS-1:0]        height;
        logic [DIM_BITS-1:0]        max_value;
        logic [HEADER_LEN_BITS-1:0] header_length;
    } result_t;

    typedef struct packed {
        pstate_t st;
        act_t    act;
        result_t res;
    } step_t;

    localparam int RES_W = $bits(result_t);

    localparam pstate_t ST_RESET = '{
        phase: PH_MAGIC0,
        field: FLD_WIDTH,
        nl:    1'b0,
        cmt:   1'b0,
        radix: RX_DEC,
        acc:   '0,
        kind:  KIND_UNKNOWN,
        wid:   '0,
        hgt:   '0,
        cnt:   '0,
        ovf:   1'b0
    };

    // ------------------------------------------------------------------
    // Parser step functions
    // ------------------------------------------------------------------

    function automatic step_t make_step(input pstate_t s, input act_t a);
        step_t r;
        r.st  = s;
        r.act = a;
        r.res = '0;
        return r;
    endfunction

    // Finish the header with a result word.
    function automatic step_t emit(input pstate_t s, input status_t st,
                                   input logic [DIM_BITS-1:0] maxv,
                                   input logic [HEADER_LEN_BITS-1:0] len);
        step_t r;
        r.st                   = s;
        r.st.phase             = PH_DONE;
        r.act                  = ACT_RESULT;
        r.res.status           = st;
        r.res.image_kind       = s.kind;
        r.res.width            = s.wid;
        r.res.height           = s.hgt;
        r.res.max_value        = maxv;
        r.res.header_length    = len;
        return r;
    endfunction

    function automatic pstate_t enter_skip(input pstate_t s, input field_t f);
        pstate_t n;
        n       = s;
        n.phase = PH_SKIP;
        n.field = f;
        n.nl    = 1'b0;
        n.cmt   = 1'b0;
        return n;
    endfunction

    // One digit into the accumulator; values past the field maximum stick at max + 1.
    function automatic logic [ACC_W-1:0] accumulate(input logic [ACC_W-1:0] a,
                                                    input radix_t rx,
                                                    input logic [3:0] d);
        logic [ACC_EXT_W-1:0] ax;
        logic [ACC_EXT_W-1:0] t;
        ax = ACC_EXT_W'(a);
        unique case (rx)
            RX_HEX:  t = ax << 4;
            RX_OCT:  t = ax << 3;
            default: t = (ax << 3) + (ax << 1);
        endcase
        t = t + ACC_EXT_W'(d);
        if (t[ACC_EXT_W-1:DIM_BITS] != '0)
        begin
            return {1'b1, {DIM_BITS{1'b0}}};
        end
        return {1'b0, t[DIM_BITS-1:0]};
    endfunction

    // End of a number: keep it and move on, or report.
    function automatic step_t finish_number(input pstate_t s);
        pstate_t                    n;
        logic                       big;
        logic [DIM_BITS-1:0]        v;
        logic [HEADER_LEN_BITS-1:0] len;
        step_t                      r;
        n   = s;
        big = s.acc[DIM_BITS];
        v   = big ? {DIM_BITS{1'b1}} : s.acc[DIM_BITS-1:0];
        len = s.cnt;
        if (s.field == FLD_WIDTH)
        begin
            if (v == '0)
            begin
                r = emit(s, ST_ZERO_W, '0, s.cnt);
            end
            else
            begin
                n.wid = v;
                n.ovf = s.ovf | big;
                r     = make_step(enter_skip(n, FLD_HEIGHT), ACT_AGAIN);
            end
        end
        else if (s.field == FLD_HEIGHT)
        begin
            if (v == '0)
            begin
                r = emit(s, ST_ZERO_H, '0, s.cnt);
            end
            else
            begin
                n.hgt = v;
                n.ovf = s.ovf | big;
                r     = make_step(enter_skip(n, FLD_MAXVAL), ACT_AGAIN);
            end
        end
        else
        begin
            // A bare "0x" ends at the x, which is the byte consumed after maxval.
            n.ovf = s.ovf | big;
            if ((s.radix == RX_HEXPEND) && (len != '0))
            begin
                len = len - HEADER_LEN_BITS'(1);
            end
            r = emit(n, n.ovf ? ST_OVERFLOW : ST_OK, v, len);
        end
        return r;
    endfunction

    // First byte after the whitespace in front of a number.
    function automatic step_t start_number(input pstate_t s, input logic [7:0] b);
        pstate_t n;
        step_t   r;
        n       = s;
        n.phase = PH_NUMBER;
        n.acc   = '0;
        n.radix = RX_DEC;
        n.nl    = 1'b0;
        if ((b >= CH_1) && (b <= CH_9))
        begin
            n.acc = ACC_W'(b[3:0]);
            r     = make_step(n, ACT_NONE);
        end
        else if (b == CH_0)
        begin
            // A lone leading zero: octal, or the start of a hex prefix.
            n.radix = RX_OCT;
            n.nl    = 1'b1;
            r       = make_step(n, ACT_NONE);
        end
        else
        begin
            r = finish_number(n);
        end
        return r;
    endfunction

    // A byte while a number is being read.
    function automatic step_t number_byte(input pstate_t s, input logic [7:0] b);
        pstate_t    n;
        logic [4:0] hx;
        step_t      r;
        n  = s;
        hx = hex_digit(b);
        if (s.radix == RX_HEXPEND)
        begin
            if (!hx[4])
            begin
                r = finish_number(s);
            end
            else
            begin
                n.radix = RX_HEX;
                n.acc   = ACC_W'(hx[3:0]);
                r       = make_step(n, ACT_NONE);
            end
        end
        else if ((s.radix == RX_OCT) && s.nl && ((b == CH_LO_X) || (b == CH_UP_X)))
        begin
            n.radix = RX_HEXPEND;
            n.nl    = 1'b0;
            r       = make_step(n, ACT_NONE);
        end
        else
        begin
            n.nl = 1'b0;
            if ((s.radix == RX_HEX) && hx[4])
            begin
                n.acc = accumulate(s.acc, RX_HEX, hx[3:0]);
                r     = make_step(n, ACT_NONE);
            end
            else if ((s.radix == RX_OCT) && (b >= CH_0) && (b <= CH_7))
            begin
                n.acc = accumulate(s.acc, RX_OCT, b[3:0]);
                r     = make_step(n, ACT_NONE);
            end
            else if ((s.radix == RX_DEC) && (b >= CH_0) && (b <= CH_9))
            begin
                n.acc = accumulate(s.acc, RX_DEC, b[3:0]);
                r     = make_step(n, ACT_NONE);
            end
            else
            begin
                r = finish_number(n);
            end
        end
        return r;
    endfunction

    // One pass of the byte through the grammar.
    function automatic step_t dispatch(input pstate_t s, input logic [7:0] b);
        pstate_t n;
        step_t   r;
        n = s;
        unique case (s.phase)
            PH_MAGIC0:
            begin
                if (b == CH_P)
                begin
                    n.phase = PH_MAGIC1;
                    r       = make_step(n, ACT_NONE);
                end
                else
                begin
                    n.kind = KIND_UNKNOWN;
                    r      = emit(n, ST_BAD_MAGIC, '0, s.cnt);
                end
            end
            PH_MAGIC1:
            begin
                if ((b == CH_5) || (b == CH_6))
                begin
                    n.kind = (b == CH_5) ? KIND_GREY : KIND_COLOUR;
                    r      = make_step(enter_skip(n, FLD_WIDTH), ACT_NONE);
                end
                else
                begin
                    n.kind = KIND_UNKNOWN;
                    r      = emit(n, ST_BAD_MAGIC, '0, s.cnt);
                end
            end
            PH_NUMBER:
            begin
                r = number_byte(s, b);
            end
            PH_SKIP_WS:
            begin
                if (is_space(b))
                begin
                    r = make_step(n, ACT_NONE);
                end
                else
                begin
                    r = start_number(s, b);
                end
            end
            PH_SKIP:
            begin
                if (s.cmt)
                begin
                    // Inside a comment (nl set) or right after one (nl clear).
                    if (s.nl)
                    begin
                        if (b == CH_NL)
                        begin
                            n.nl = 1'b0;
                        end
                        r = make_step(n, ACT_NONE);
                    end
                    else if (b == CH_HASH)
                    begin
                        n.nl = 1'b1;
                        r    = make_step(n, ACT_NONE);
                    end
                    else if (is_space(b))
                    begin
                        n.phase = PH_SKIP_WS;
                        r       = make_step(n, ACT_NONE);
                    end
                    else
                    begin
                        r = start_number(s, b);
                    end
                end
                else if (is_space(b))
                begin
                    n.nl = (b == CH_NL);
                    r    = make_step(n, ACT_NONE);
                end
                else if ((b == CH_HASH) && s.nl)
                begin
                    n.cmt = 1'b1;
                    n.nl  = 1'b1;
                    r     = make_step(n, ACT_NONE);
                end
                else
                begin
                    r = start_number(s, b);
                end
            end
            default:
            begin
                r = make_step(n, ACT_NONE);
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;
    logic       room;
    logic       proceed;
    logic       in_take;

    assign proceed     = in_valid_reg && room;
    assign bytes.ready = !in_valid_reg || proceed;
    assign in_take     = bytes.valid && bytes.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= bytes.data_byte;
            in_first_reg <= bytes.first_byte;
            in_last_reg  <= bytes.last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state and per-byte logic
    // ------------------------------------------------------------------

    pstate_t state_reg;
    pstate_t state_next;
    logic    res_valid;
    result_t res_word;

    // A field-ending byte is handled twice: it also opens the next separator.
    always_comb
    begin
        pstate_t s0;
        step_t   r1;
        step_t   r2;
        s0        = in_first_reg ? ST_RESET : state_reg;
        r1        = make_step(s0, ACT_NONE);
        r2        = r1;
        res_valid = 1'b0;
        res_word  = '0;
        if (s0.phase == PH_DONE)
        begin
            state_next = s0;
        end
        else
        begin
            if (s0.cnt != {HEADER_LEN_BITS{1'b1}})
            begin
                s0.cnt = s0.cnt + HEADER_LEN_BITS'(1);
            end
            r1 = dispatch(s0, in_byte_reg);
            r2 = (r1.act == ACT_AGAIN) ? dispatch(r1.st, in_byte_reg) : r1;
            if ((r2.act != ACT_RESULT) && in_last_reg && (r2.st.phase != PH_DONE))
            begin
                r2 = emit(r2.st, ST_TRUNC, '0, r2.st.cnt);
            end
            state_next = r2.st;
            res_valid  = (r2.act == ACT_RESULT);
            res_word   = r2.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET;
        end
        else if (proceed)
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------

    logic [RES_W-1:0] buf_data;
    result_t          out_word;

    pnmhp_out_buf
    #(
        .DATA_W (RES_W)
    )
    u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (proceed && res_valid),
        .push_data  (res_word),
        .room       (room),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (buf_data)
    );

    assign out_word             = result_t'(buf_data);
    assign result.status        = out_word.status;
    assign result.image_kind    = out_word.image_kind;
    assign result.width         = out_word.width;
    assign result.height        = out_word.height;
    assign result.max_value     = out_word.max_value;
    assign result.header_length = out_word.header_length;

endmodule

`default_nettype wire
